// ===== hw/rtl/uart_rb_pkg.sv =====
// Shared constants, command codes and controller/datapath interface types.
`timescale 1ns / 1ps
`default_nettype none
package uart_rb_pkg;

  localparam int RING_DEPTH = 16;
  localparam int PTR_W      = (RING_DEPTH > 1) ? $clog2(RING_DEPTH) : 1;
  localparam int CNT_W      = PTR_W + 1;
  localparam int RX_COUNT_W = 4;
  localparam int BYTE_W     = 8;
  localparam int APB_DATA_W = 32;
  localparam int APB_ADDR_W = 3;

  localparam logic [BYTE_W-1:0] DELIM_RESET = 8'd36;
  localparam logic              REG_DELIM   = 1'b0;

  typedef enum logic [1:0] {
    CMD_SEND      = 2'd0,
    CMD_TX_DONE   = 2'd1,
    CMD_RX_BYTE   = 2'd2,
    CMD_HOST_READ = 2'd3
  } rb_op_t;

  typedef struct packed {
    logic capture;
    logic push_tx;
    logic push_rx;
    logic fetch;
    logic finish;
    logic pop_tx;
    logic pop_rx;
    logic drop;
    logic clr_busy;
  } rb_ctl_t;

  typedef struct packed {
    logic tx_full;
    logic tx_empty;
    logic rx_full;
    logic rx_empty;
    logic tx_busy;
  } rb_sts_t;

endpackage
`default_nettype wire

// ===== hw/rtl/uart_rb_ctrl.sv =====
// Request sequencer for the ring buffers: decides pushes, pops and drops.
`timescale 1ns / 1ps
`default_nettype none
module uart_rb_ctrl import uart_rb_pkg::*; (
  input  wire logic       clk,
  input  wire logic       rst_n,
  input  wire logic       start,
  input  wire logic [1:0] in_cmd,
  input  wire rb_sts_t    sts,
  output rb_ctl_t         ctl,
  output logic            busy
);

  typedef enum logic [3:0] {
    ST_IDLE  = 4'b0001,
    ST_EXEC  = 4'b0010,
    ST_FETCH = 4'b0100,
    ST_DONE  = 4'b1000
  } rb_state_t;

  rb_state_t state_r, state_nxt;
  rb_op_t    cmd_r, cmd_nxt;
  logic      pop_tx_r, pop_tx_nxt;
  logic      pop_rx_r, pop_rx_nxt;
  logic      drop_r, drop_nxt;
  logic      clr_r, clr_nxt;

  always_comb begin
    state_nxt  = state_r;
    cmd_nxt    = cmd_r;
    pop_tx_nxt = pop_tx_r;
    pop_rx_nxt = pop_rx_r;
    drop_nxt   = drop_r;
    clr_nxt    = clr_r;
    ctl        = '0;
    unique case (state_r)
      ST_IDLE: begin
        if (start) begin
          ctl.capture = 1'b1;
          cmd_nxt     = rb_op_t'(in_cmd);
          state_nxt   = ST_EXEC;
        end
      end
      ST_EXEC: begin
        pop_tx_nxt = 1'b0;
        pop_rx_nxt = 1'b0;
        drop_nxt   = 1'b0;
        clr_nxt    = 1'b0;
        unique case (cmd_r)
          CMD_SEND: begin
            if (sts.tx_full) begin
              drop_nxt = 1'b1;
            end else begin
              ctl.push_tx = 1'b1;
              pop_tx_nxt  = !sts.tx_busy;
            end
          end
          CMD_TX_DONE: begin
            pop_tx_nxt = !sts.tx_empty;
            clr_nxt    = sts.tx_empty;
          end
          CMD_RX_BYTE: begin
            if (sts.rx_full) begin
              drop_nxt = 1'b1;
            end else begin
              ctl.push_rx = 1'b1;
            end
          end
          CMD_HOST_READ: begin
            pop_rx_nxt = !sts.rx_empty;
          end
          default: begin
          end
        endcase
        state_nxt = ST_FETCH;
      end
      ST_FETCH: begin
        ctl.fetch = 1'b1;
        state_nxt = ST_DONE;
      end
      ST_DONE: begin
        ctl.finish   = 1'b1;
        ctl.pop_tx   = pop_tx_r;
        ctl.pop_rx   = pop_rx_r;
        ctl.drop     = drop_r;
        ctl.clr_busy = clr_r;
        state_nxt    = ST_IDLE;
      end
      default: begin
        state_nxt = ST_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r  <= ST_IDLE;
      cmd_r    <= CMD_SEND;
      pop_tx_r <= 1'b0;
      pop_rx_r <= 1'b0;
      drop_r   <= 1'b0;
      clr_r    <= 1'b0;
    end else begin
      state_r  <= state_nxt;
      cmd_r    <= cmd_nxt;
      pop_tx_r <= pop_tx_nxt;
      pop_rx_r <= pop_rx_nxt;
      drop_r   <= drop_nxt;
      clr_r    <= clr_nxt;
    end
  end

  assign busy = (state_r != ST_IDLE);

endmodule
`default_nettype wire

// ===== hw/rtl/uart_rb_dp.sv =====
// Ring buffer datapath: byte memories, pointers, busy flag and result registers.
`timescale 1ns / 1ps
`default_nettype none
module uart_rb_dp import uart_rb_pkg::*; (
  input  wire logic                  clk,
  input  wire logic                  rst_n,
  input  wire rb_ctl_t               ctl,
  input  wire logic [BYTE_W-1:0]     in_data,
  input  wire logic [BYTE_W-1:0]     delimiter,
  output rb_sts_t                    sts,
  output logic                       out_valid,
  output logic                       out_line_valid,
  output logic [BYTE_W-1:0]          out_line_byte,
  output logic                       out_read_valid,
  output logic [BYTE_W-1:0]          out_read_byte,
  output logic                       out_read_is_delimiter,
  output logic                       out_dropped,
  output logic                       out_tx_busy,
  output logic [RX_COUNT_W-1:0]      out_rx_count
);

  localparam int WIDE_W = (CNT_W > RX_COUNT_W) ? CNT_W : RX_COUNT_W;
  localparam logic [PTR_W-1:0] LAST_SLOT = PTR_W'(RING_DEPTH - 1);
  localparam logic [CNT_W-1:0] DEPTH_C   = CNT_W'(RING_DEPTH);

  function automatic logic [PTR_W-1:0] ring_next(input logic [PTR_W-1:0] p);
    ring_next = (p == LAST_SLOT) ? '0 : p + PTR_W'(1);
  endfunction

  logic [BYTE_W-1:0] tx_mem [RING_DEPTH];
  logic [BYTE_W-1:0] rx_mem [RING_DEPTH];

  logic [BYTE_W-1:0] data_r;
  logic [BYTE_W-1:0] rd_tx_r;
  logic [BYTE_W-1:0] rd_rx_r;
  logic [PTR_W-1:0]  tx_head_r, tx_tail_r, rx_head_r, rx_tail_r;
  logic [PTR_W-1:0]  rx_tail_nxt;
  logic              busy_r, busy_nxt;
  logic [CNT_W-1:0]  rx_cnt;
  logic [WIDE_W-1:0] rx_cnt_wide;

  logic                  valid_r;
  logic                  line_valid_r, read_valid_r, is_delim_r, dropped_r, tx_busy_r;
  logic [BYTE_W-1:0]     line_byte_r, read_byte_r;
  logic [RX_COUNT_W-1:0] rx_count_r;

  assign sts.tx_full  = (ring_next(tx_head_r) == tx_tail_r);
  assign sts.tx_empty = (tx_head_r == tx_tail_r);
  assign sts.rx_full  = (ring_next(rx_head_r) == rx_tail_r);
  assign sts.rx_empty = (rx_head_r == rx_tail_r);
  assign sts.tx_busy  = busy_r;

  always_comb begin
    rx_tail_nxt = ctl.pop_rx ? ring_next(rx_tail_r) : rx_tail_r;
    busy_nxt    = busy_r;
    if (ctl.pop_tx) begin
      busy_nxt = 1'b1;
    end else if (ctl.clr_busy) begin
      busy_nxt = 1'b0;
    end
    // occupancy after the pop, folded back into the ring
    if (rx_head_r >= rx_tail_nxt) begin
      rx_cnt = {1'b0, rx_head_r} - {1'b0, rx_tail_nxt};
    end else begin
      rx_cnt = {1'b0, rx_head_r} + DEPTH_C - {1'b0, rx_tail_nxt};
    end
    rx_cnt_wide = WIDE_W'(rx_cnt);
  end

  // byte memories: one write port, one registered read port each
  always_ff @(posedge clk) begin
    if (ctl.push_tx) begin
      tx_mem[tx_head_r] <= data_r;
    end
    if (ctl.push_rx) begin
      rx_mem[rx_head_r] <= data_r;
    end
    if (ctl.fetch) begin
      rd_tx_r <= tx_mem[tx_tail_r];
      rd_rx_r <= rx_mem[rx_tail_r];
    end
  end

  always_ff @(posedge clk) begin
    if (ctl.capture) begin
      data_r <= in_data;
    end
    if (ctl.finish) begin
      line_valid_r <= ctl.pop_tx;
      line_byte_r  <= ctl.pop_tx ? rd_tx_r : '0;
      read_valid_r <= ctl.pop_rx;
      read_byte_r  <= ctl.pop_rx ? rd_rx_r : '0;
      is_delim_r   <= ctl.pop_rx && (rd_rx_r == delimiter);
      dropped_r    <= ctl.drop;
      tx_busy_r    <= busy_nxt;
      rx_count_r   <= rx_cnt_wide[RX_COUNT_W-1:0];
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      tx_head_r <= '0;
      tx_tail_r <= '0;
      rx_head_r <= '0;
      rx_tail_r <= '0;
      busy_r    <= 1'b0;
      valid_r   <= 1'b0;
    end else begin
      valid_r <= ctl.finish;
      if (ctl.push_tx) begin
        tx_head_r <= ring_next(tx_head_r);
      end
      if (ctl.push_rx) begin
        rx_head_r <= ring_next(rx_head_r);
      end
      if (ctl.pop_tx) begin
        tx_tail_r <= ring_next(tx_tail_r);
      end
      rx_tail_r <= rx_tail_nxt;
      busy_r    <= busy_nxt;
    end
  end

  assign out_valid             = valid_r;
  assign out_line_valid        = line_valid_r;
  assign out_line_byte         = line_byte_r;
  assign out_read_valid        = read_valid_r;
  assign out_read_byte         = read_byte_r;
  assign out_read_is_delimiter = is_delim_r;
  assign out_dropped           = dropped_r;
  assign out_tx_busy           = tx_busy_r;
  assign out_rx_count          = rx_count_r;

endmodule
`default_nettype wire

// ===== hw/rtl/uart_tx_rx_ring_buffers_core.sv =====
// Top level of the UART transmit/receive ring buffers with APB register port.
//
// Channel    | Handshake                 | Payload
// -----------+---------------------------+----------------------------------------
// request    | start, busy (take: !busy) | in_cmd[1:0], in_data[7:0]
// result     | out_valid (1-cycle strobe)| out_line_*, out_read_*, out_dropped,
//            |                           | out_tx_busy, out_rx_count[3:0]
// config     | APB psel/penable/pwrite   | paddr[2:0], pwdata, prdata (delimiter @0)
//
// A request passes through accept, execute (push and pointer decisions), fetch
// (registered memory read at the ring tails) and done; the result strobes in the
// cycle after done, while the next request can already be accepted.
// The sequence is shaped by the registered read port of the byte memories.
// Reset (rst_n low, synchronous) empties both rings, clears busy and loads '$'.
// The result receiver cannot stall; each result shows for exactly one cycle.
`timescale 1ns / 1ps
`default_nettype none
module uart_tx_rx_ring_buffers_core import uart_rb_pkg::*; (
  input  wire logic                  clk,
  input  wire logic                  rst_n,
  // request channel
  input  wire logic                  start,
  output logic                       busy,
  input  wire logic [1:0]            in_cmd,
  input  wire logic [BYTE_W-1:0]     in_data,
  // result channel
  output logic                       out_valid,
  output logic                       out_line_valid,
  output logic [BYTE_W-1:0]          out_line_byte,
  output logic                       out_read_valid,
  output logic [BYTE_W-1:0]          out_read_byte,
  output logic                       out_read_is_delimiter,
  output logic                       out_dropped,
  output logic                       out_tx_busy,
  output logic [RX_COUNT_W-1:0]      out_rx_count,
  // configuration port
  input  wire logic                  psel,
  input  wire logic                  penable,
  input  wire logic                  pwrite,
  input  wire logic [APB_ADDR_W-1:0] paddr,
  input  wire logic [APB_DATA_W-1:0] pwdata,
  output logic [APB_DATA_W-1:0]      prdata,
  output logic                       pready
);

  rb_ctl_t           ctl;
  rb_sts_t           sts;
  logic [BYTE_W-1:0] delim_r;
  logic              reg_hit;

  // Word address selects the register; byte lanes within the word are ignored.
  assign reg_hit = (paddr[2] == REG_DELIM);
  assign pready  = 1'b1;

  // Hold the delimiter; write on the access phase of an APB write.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      delim_r <= DELIM_RESET;
    end else if (psel && penable && pwrite && pready && reg_hit) begin
      delim_r <= pwdata[BYTE_W-1:0];
    end
  end

  // Return the delimiter on its address, zero elsewhere.
  assign prdata = reg_hit ? {{(APB_DATA_W-BYTE_W){1'b0}}, delim_r} : '0;

  // Controller: decode the request and sequence push, fetch and pop.
  uart_rb_ctrl u_ctrl (
    .clk    (clk),
    .rst_n  (rst_n),
    .start  (start),
    .in_cmd (in_cmd),
    .sts    (sts),
    .ctl    (ctl),
    .busy   (busy)
  );

  // Datapath: rings, pointers, busy flag and result registers.
  uart_rb_dp u_dp (
    .clk                   (clk),
    .rst_n                 (rst_n),
    .ctl                   (ctl),
    .in_data               (in_data),
    .delimiter             (delim_r),
    .sts                   (sts),
    .out_valid             (out_valid),
    .out_line_valid        (out_line_valid),
    .out_line_byte         (out_line_byte),
    .out_read_valid        (out_read_valid),
    .out_read_byte         (out_read_byte),
    .out_read_is_delimiter (out_read_is_delimiter),
    .out_dropped           (out_dropped),
    .out_tx_busy           (out_tx_busy),
    .out_rx_count          (out_rx_count)
  );

  // Every accepted request yields its result strobe.
  a_result_latency: assert property (@(posedge clk) disable iff (!rst_n)
    (start && !busy) |-> ##4 out_valid)
    else $error("result strobe missing after accepted request");

  // A byte handed to the line leaves the transmitter busy.
  a_line_sets_busy: assert property (@(posedge clk) disable iff (!rst_n)
    (out_valid && out_line_valid) |-> out_tx_busy)
    else $error("line handover without busy flag");

  // A dropped request neither hands a byte over nor returns one.
  a_drop_exclusive: assert property (@(posedge clk) disable iff (!rst_n)
    (out_valid && out_dropped) |-> (!out_line_valid && !out_read_valid))
    else $error("dropped request produced data");

  // A host read never coincides with a line handover.
  a_read_vs_line: assert property (@(posedge clk) disable iff (!rst_n)
    (out_valid && out_read_valid) |-> !out_line_valid)
    else $error("read and line handover in one result");

endmodule
`default_nettype wire

// ===== sim/tb.sv =====
`timescale 1ns / 1ps
// Self-checking testbench for the UART transmit/receive ring buffer core.
//
// A queue filled at time zero feeds a clocked driver with requests (host send,
// transmit done, line byte received, host read), delimiter register writes
// over the APB-style port, and hold points. The driver predicts each accepted
// request with its own model of both rings. A clocked monitor compares every
// strobed result with the oldest prediction.
module tb;
  import uart_rb_pkg::*;

  localparam int N_RANDOM      = 1125;
  localparam int N_PHASES      = 5;
  localparam int IDLE_PCT      = 19;
  // long enough for a request to run through and its result to strobe
  localparam int SETTLE_CYCLES = 8;
  localparam int CALM_FIRST    = 500;
  localparam int CALM_LAST     = 700;
  localparam int REG_UNMAPPED  = 1;
  localparam int LIMIT_NS      = 4_000_000;

  localparam logic [APB_ADDR_W-1:0] DELIM_ADDR    = APB_ADDR_W'(4 * int'(REG_DELIM));
  localparam logic [APB_ADDR_W-1:0] UNMAPPED_ADDR = APB_ADDR_W'(4 * REG_UNMAPPED);

  typedef enum logic [1:0] {ENT_REQ, ENT_CFG, ENT_HOLD} entry_kind_t;
  typedef enum logic [2:0] {APB_IDLE, APB_WR, APB_WR_ACC, APB_RD, APB_RD_ACC} apb_state_t;

  typedef struct {
    entry_kind_t           kind;
    rb_op_t                op;
    logic [BYTE_W-1:0]     data;
    logic [APB_ADDR_W-1:0] addr;
    logic [APB_DATA_W-1:0] wdata;
  } ring_entry_t;

  typedef struct packed {
    logic                  line_valid;
    logic [BYTE_W-1:0]     line_byte;
    logic                  read_valid;
    logic [BYTE_W-1:0]     read_byte;
    logic                  read_is_delim;
    logic                  dropped;
    logic                  tx_busy;
    logic [RX_COUNT_W-1:0] rx_count;
  } ring_result_t;

  // DUT ports; every input starts at a known value
  logic                  clk     = 1'b0;
  logic                  rst_n   = 1'b0;
  logic                  start   = 1'b0;
  logic                  busy;
  logic [1:0]            in_cmd  = '0;
  logic [BYTE_W-1:0]     in_data = '0;
  logic                  out_valid;
  logic                  out_line_valid;
  logic [BYTE_W-1:0]     out_line_byte;
  logic                  out_read_valid;
  logic [BYTE_W-1:0]     out_read_byte;
  logic                  out_read_is_delimiter;
  logic                  out_dropped;
  logic                  out_tx_busy;
  logic [RX_COUNT_W-1:0] out_rx_count;
  logic                  psel    = 1'b0;
  logic                  penable = 1'b0;
  logic                  pwrite  = 1'b0;
  logic [APB_ADDR_W-1:0] paddr   = '0;
  logic [APB_DATA_W-1:0] pwdata  = '0;
  logic [APB_DATA_W-1:0] prdata;
  logic                  pready;

  uart_tx_rx_ring_buffers_core dut (
    .clk                  (clk),
    .rst_n                (rst_n),
    .start                (start),
    .busy                 (busy),
    .in_cmd               (in_cmd),
    .in_data              (in_data),
    .out_valid            (out_valid),
    .out_line_valid       (out_line_valid),
    .out_line_byte        (out_line_byte),
    .out_read_valid       (out_read_valid),
    .out_read_byte        (out_read_byte),
    .out_read_is_delimiter(out_read_is_delimiter),
    .out_dropped          (out_dropped),
    .out_tx_busy          (out_tx_busy),
    .out_rx_count         (out_rx_count),
    .psel                 (psel),
    .penable              (penable),
    .pwrite               (pwrite),
    .paddr                (paddr),
    .pwdata               (pwdata),
    .prdata               (prdata),
    .pready               (pready)
  );

  // Stimulus backlog, predicted results not yet seen, bookkeeping
  ring_entry_t  ring_requests[$];
  ring_result_t ring_results_due[$];
  int           fault_count  = 0;
  int           accepted     = 0;
  int           quiet_cycles = 0;
  apb_state_t   apb_state    = APB_IDLE;

  // Shadow of the block: both rings, their pointers, busy flag, delimiter.
  // Reset values are loaded at declaration since reset is applied only once.
  logic [BYTE_W-1:0] tx_ring [RING_DEPTH];
  logic [BYTE_W-1:0] rx_ring [RING_DEPTH];
  logic [PTR_W-1:0]  tx_wr        = '0;
  logic [PTR_W-1:0]  tx_rd        = '0;
  logic [PTR_W-1:0]  rx_wr        = '0;
  logic [PTR_W-1:0]  rx_rd        = '0;
  logic              tx_active    = 1'b0;
  logic [BYTE_W-1:0] delim_shadow = DELIM_RESET;

  initial begin
    forever #4 clk = ~clk;
  end

  // Hard stop in case the handshake hangs
  initial begin
    #(LIMIT_NS);
    $display("FAIL");
    $finish;
  end

  function automatic logic [PTR_W-1:0] ring_adv(logic [PTR_W-1:0] p);
    return (int'(p) == RING_DEPTH - 1) ? '0 : p + 1'b1;
  endfunction

  // Pop the oldest transmit byte onto the line, or go idle when the ring is empty
  function automatic void hand_to_line(inout ring_result_t r);
    if (tx_wr == tx_rd) begin
      tx_active = 1'b0;
    end else begin
      r.line_valid = 1'b1;
      r.line_byte  = tx_ring[tx_rd];
      tx_rd        = ring_adv(tx_rd);
      tx_active    = 1'b1;
    end
  endfunction

  // Advance the shadow rings by one request and return the result it causes
  function automatic ring_result_t predict_ring_result(rb_op_t op, logic [BYTE_W-1:0] data);
    ring_result_t     r;
    logic [PTR_W-1:0] nxt;
    r = '0;
    case (op)
      CMD_SEND: begin
        nxt = ring_adv(tx_wr);
        if (nxt == tx_rd) begin
          r.dropped = 1'b1;
        end else begin
          tx_ring[tx_wr] = data;
          tx_wr          = nxt;
          if (!tx_active) hand_to_line(r);
        end
      end
      CMD_TX_DONE: begin
        hand_to_line(r);
      end
      CMD_RX_BYTE: begin
        nxt = ring_adv(rx_wr);
        if (nxt == rx_rd) begin
          r.dropped = 1'b1;
        end else begin
          rx_ring[rx_wr] = data;
          rx_wr          = nxt;
        end
      end
      default: begin
        if (rx_wr != rx_rd) begin
          r.read_valid    = 1'b1;
          r.read_byte     = rx_ring[rx_rd];
          r.read_is_delim = (rx_ring[rx_rd] == delim_shadow);
          rx_rd           = ring_adv(rx_rd);
        end
      end
    endcase
    r.tx_busy  = tx_active;
    r.rx_count = RX_COUNT_W'((int'(rx_wr) + RING_DEPTH - int'(rx_rd)) % RING_DEPTH);
    return r;
  endfunction

  // Driver: launch requests, register writes and hold points from the backlog
  always @(posedge clk) begin
    ring_entry_t ent;
    logic        nxt_start;
    logic        calm;
    if (!rst_n) begin
      start   <= 1'b0;
      psel    <= 1'b0;
      penable <= 1'b0;
      pwrite  <= 1'b0;
    end else begin
      nxt_start = start;
      // Predict the request that the block takes at this edge
      if (start && !busy) begin
        ring_results_due.push_back(predict_ring_result(rb_op_t'(in_cmd), in_data));
        accepted++;
        nxt_start = 1'b0;
      end
      // Count settled cycles: nothing pending, nothing offered, port quiet
      if (ring_results_due.size() == 0 && !nxt_start && apb_state == APB_IDLE) begin
        quiet_cycles++;
      end else begin
        quiet_cycles = 0;
      end
      calm = (accepted >= CALM_FIRST && accepted < CALM_LAST);

      case (apb_state)
        APB_WR: begin
          penable   <= 1'b1;
          apb_state = APB_WR_ACC;
        end
        APB_WR_ACC: begin
          if (pready) begin
            // The write lands at this edge; only the delimiter address is mapped
            if (paddr == DELIM_ADDR) delim_shadow = pwdata[BYTE_W-1:0];
            penable   <= 1'b0;
            pwrite    <= 1'b0;
            paddr     <= DELIM_ADDR;
            apb_state = APB_RD;
          end
        end
        APB_RD: begin
          penable   <= 1'b1;
          apb_state = APB_RD_ACC;
        end
        APB_RD_ACC: begin
          if (pready) begin
            // Read back the delimiter to confirm what the write did
            if (prdata[BYTE_W-1:0] !== delim_shadow) begin
              $display("%0t: delimiter readback expected %0h got %0h",
                       $time, delim_shadow, prdata[BYTE_W-1:0]);
              fault_count++;
            end
            psel      <= 1'b0;
            penable   <= 1'b0;
            apb_state = APB_IDLE;
          end
        end
        default: begin
          if (!nxt_start && ring_requests.size() > 0) begin
            ent = ring_requests[0];
            case (ent.kind)
              ENT_REQ: begin
                // Idle at random, except inside the calm window
                if (calm || $urandom_range(99) >= IDLE_PCT) begin
                  in_cmd    <= ent.op;
                  in_data   <= ent.data;
                  nxt_start = 1'b1;
                  void'(ring_requests.pop_front());
                end
              end
              ENT_HOLD: begin
                if (quiet_cycles >= SETTLE_CYCLES) void'(ring_requests.pop_front());
              end
              default: begin
                // Write registers only once the block has drained and settled
                if (quiet_cycles >= SETTLE_CYCLES) begin
                  psel      <= 1'b1;
                  penable   <= 1'b0;
                  pwrite    <= 1'b1;
                  paddr     <= ent.addr;
                  pwdata    <= ent.wdata;
                  apb_state = APB_WR;
                  void'(ring_requests.pop_front());
                end
              end
            endcase
          end
        end
      endcase
      start <= nxt_start;
    end
  end

  task automatic check_field(string name, int want, int got);
    if (want != got) begin
      $display("%0t: %s expected %0h got %0h", $time, name, want, got);
      fault_count++;
    end
  endtask

  // Monitor: each strobe is one result, matched against the oldest prediction
  always @(posedge clk) begin
    ring_result_t want;
    ring_result_t got;
    if (rst_n && out_valid) begin
      got = {out_line_valid, out_line_byte, out_read_valid, out_read_byte,
             out_read_is_delimiter, out_dropped, out_tx_busy, out_rx_count};
      if (ring_results_due.size() == 0) begin
        $display("%0t: unexpected result, expected none got %h", $time, got);
        fault_count++;
      end else begin
        want = ring_results_due.pop_front();
        check_field("line_valid", want.line_valid, got.line_valid);
        check_field("line_byte", want.line_byte, got.line_byte);
        check_field("read_valid", want.read_valid, got.read_valid);
        check_field("read_byte", want.read_byte, got.read_byte);
        check_field("read_is_delimiter", want.read_is_delim, got.read_is_delim);
        check_field("dropped", want.dropped, got.dropped);
        check_field("tx_busy", want.tx_busy, got.tx_busy);
        check_field("rx_count", want.rx_count, got.rx_count);
      end
    end
  end

  task automatic add_req(rb_op_t op, logic [BYTE_W-1:0] data);
    ring_entry_t e;
    e       = '{kind: ENT_REQ, op: op, data: data, addr: '0, wdata: '0};
    ring_requests.push_back(e);
  endtask

  task automatic add_cfg(logic [APB_ADDR_W-1:0] addr, logic [APB_DATA_W-1:0] wdata);
    ring_entry_t e;
    e       = '{kind: ENT_CFG, op: CMD_SEND, data: '0, addr: addr, wdata: wdata};
    ring_requests.push_back(e);
  endtask

  // One burst of random requests, with a bias that fills or drains one ring in four of its six modes
  task automatic add_burst(int n, logic [BYTE_W-1:0] delim);
    int                mode;
    int                roll;
    rb_op_t            op;
    logic [BYTE_W-1:0] d;
    mode = $urandom_range(5);
    repeat (n) begin
      roll = $urandom_range(99);
      op   = rb_op_t'($urandom_range(3));
      case (mode)
        0: if (roll < 85) op = CMD_SEND; else if (roll < 95) op = CMD_TX_DONE;
        1: if (roll < 70) op = CMD_TX_DONE; else if (roll < 90) op = CMD_SEND;
        2: if (roll < 85) op = CMD_RX_BYTE; else if (roll < 95) op = CMD_HOST_READ;
        3: if (roll < 70) op = CMD_HOST_READ; else if (roll < 95) op = CMD_RX_BYTE;
        default: ;
      endcase
      d = $urandom_range(255);
      // steer some received bytes onto the delimiter so the flag gets hit
      if (op == CMD_RX_BYTE && $urandom_range(4) == 0) d = delim;
      add_req(op, d);
    end
  endtask

  // Backlog, reset and end of run
  initial begin
    logic [BYTE_W-1:0] plan [N_PHASES];
    ring_entry_t       hold;
    int                quota;
    int                made;
    int                n;
    logic              held;

    // Directed: empty read, idle transmit done, delimiter hit and miss,
    // extremes of data, then fill the transmit ring until a send is dropped
    add_req(CMD_HOST_READ, 8'h00);
    add_req(CMD_TX_DONE, 8'hFF);
    add_req(CMD_RX_BYTE, DELIM_RESET);
    add_req(CMD_RX_BYTE, 8'h00);
    add_req(CMD_RX_BYTE, 8'hFF);
    repeat (4) add_req(CMD_HOST_READ, BYTE_W'($urandom_range(255)));
    for (int i = 0; i <= RING_DEPTH; i++) begin
      add_req(CMD_SEND, (i == 0) ? 8'h00 : (i == 1) ? 8'hFF : BYTE_W'($urandom_range(255)));
    end

    // Random phases, each under its own delimiter
    plan[0] = 8'hFF;
    plan[1] = 8'h00;
    plan[2] = BYTE_W'($urandom_range(255));
    plan[3] = 8'h80;
    plan[4] = DELIM_RESET;
    hold    = '{kind: ENT_HOLD, op: CMD_SEND, data: '0, addr: '0, wdata: '0};
    held    = 1'b0;
    quota   = N_RANDOM / N_PHASES;
    for (int p = 0; p < N_PHASES; p++) begin
      // an unmapped address must leave the delimiter alone
      if (p == 2) add_cfg(UNMAPPED_ADDR, $urandom);
      add_cfg(DELIM_ADDR, {24'($urandom), plan[p]});
      made = 0;
      while (made < quota) begin
        n = $urandom_range(48, 8);
        if (n > quota - made) n = quota - made;
        add_burst(n, plan[p]);
        made += n;
        // stall the sender once until every pending result is back
        if (p == 1 && !held && made >= quota / 2) begin
          ring_requests.push_back(hold);
          held = 1'b1;
        end
      end
    end

    repeat (2) @(posedge clk);
    rst_n <= 1'b1;

    // Wait for the backlog to drain and every predicted result to arrive
    do @(posedge clk);
    while (ring_requests.size() != 0 || start || apb_state != APB_IDLE ||
           ring_results_due.size() != 0);
    repeat (2 * SETTLE_CYCLES) @(posedge clk);

    if (fault_count == 0) begin
      $display("PASS");
    end else begin
      $display("FAIL");
    end
    $finish;
  end

endmodule
